[src/lidar_point_camera_projection_defines.svh]
// Assertion macros for the lidar point camera projection block.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define LPCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lpcp check failed");
`define LPCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpcp check failed");
`else
`define LPCP_ASSERT(lbl, prop)
`define LPCP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/lpcp_pkg.sv]
// Shared constants, register map and pipeline types of the lidar point projection block.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
`default_nettype none
package lpcp_pkg;
  localparam int MAX_IMAGE_DIM = 4096;
  localparam int DIM_W         = $clog2(MAX_IMAGE_DIM + 1);
  localparam int NUM_REGS      = 8;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = $clog2(NUM_REGS) + 3;
  localparam int COORD_W       = 24;
  localparam int INT_W         = 16;
  localparam int CODE_W        = 8;
  localparam int DEPTH_LIMIT   = 10240;
  localparam int CODE_SCALE    = 254;
  // divisor is 2*z*256, numerator 2*nu + z*256
  localparam int DEN_W         = COORD_W - 1 + 8 + 1;
  localparam int NUM_W         = DEN_W + DIM_W + 1;

  localparam logic [2:0] REG_ROT_X = 3'd0;
  localparam logic [2:0] REG_ROT_Y = 3'd1;
  localparam logic [2:0] REG_ROT_Z = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_PRINC = 3'd5;
  localparam logic [2:0] REG_SIZE  = 3'd6;
  localparam logic [2:0] REG_GAIN  = 3'd7;

  localparam logic [NUM_REGS-1:0][DATA_W-1:0] REG_MASK = {
    64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
    64'h0FFF_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF
  };

  localparam logic [NUM_REGS-1:0][DATA_W-1:0] REG_RESET = {
    64'd65536, 64'd31457920, 64'd1030792232960, 64'd2147483776000,
    64'd0, 64'd70368744177664, 64'd1073741824, 64'd16384
  };

  typedef struct packed {
    logic [2:0][2:0][15:0] rot;
    logic [2:0][19:0]      trans;
    logic [23:0]           fx;
    logic [23:0]           fy;
    logic [23:0]           cx;
    logic [23:0]           cy;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [31:0]           gain;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cam_t;

  typedef struct packed {
    cam_t             cam;
    logic [INT_W-1:0] intensity;
  } xf_t;

  typedef struct packed {
    cam_t              cam;
    logic              vis;
    logic [CODE_W-1:0] label;
    logic [CODE_W-1:0] dcode;
    logic [NUM_W-1:0]  rem_u;
    logic [NUM_W-1:0]  rem_v;
    logic [NUM_W-1:0]  den_sh;
    logic [DIM_W-1:0]  q_u;
    logic [DIM_W-1:0]  q_v;
  } div_t;
endpackage
`default_nettype wire

[src/lpcp_if.sv]
// Stream interfaces for the point input channel and the projection result channel.
// Depends on lpcp_pkg for field widths.
`default_nettype none
interface lpcp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lpcp_pkg::COORD_W-1:0]     point_x;
  logic signed [lpcp_pkg::COORD_W-1:0]     point_y;
  logic signed [lpcp_pkg::COORD_W-1:0]     point_z;
  logic        [lpcp_pkg::INT_W-1:0]       point_intensity;
  modport source (output valid, point_x, point_y, point_z, point_intensity, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_intensity, output ready);
endinterface

interface lpcp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpcp_pkg::COORD_W-1:0] cam_x;
  logic signed [lpcp_pkg::COORD_W-1:0] cam_y;
  logic signed [lpcp_pkg::COORD_W-1:0] cam_z;
  logic                                visible;
  logic [lpcp_pkg::DIM_W-1:0]          pixel_col;
  logic [lpcp_pkg::DIM_W-1:0]          pixel_row;
  logic [lpcp_pkg::CODE_W-1:0]         label_code;
  logic [lpcp_pkg::CODE_W-1:0]         distance_code;
  modport source (output valid, cam_x, cam_y, cam_z, visible, pixel_col, pixel_row,
                  label_code, distance_code, input ready);
  modport sink   (input valid, cam_x, cam_y, cam_z, visible, pixel_col, pixel_row,
                  label_code, distance_code, output ready);
endinterface
`default_nettype wire

[src/lpcp_regs.sv]
// APB-style configuration register file; presents the decoded configuration.
// Depends on lpcp_pkg (register map, reset values, cfg_t).
`default_nettype none
module lpcp_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lpcp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lpcp_pkg::DATA_W-1:0]   pwdata,
  output logic      [lpcp_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output lpcp_pkg::cfg_t                     cfg
);
  logic [lpcp_pkg::DATA_W-1:0] regs_r [lpcp_pkg::NUM_REGS];
  logic [2:0]                  idx;
  logic [15:0]                 w_raw;
  logic [15:0]                 h_raw;

  assign idx    = paddr[lpcp_pkg::ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = regs_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpcp_pkg::NUM_REGS; i++) begin
        regs_r[i] <= lpcp_pkg::REG_RESET[i];
      end
    end else if (psel && penable && pwrite) begin
      regs_r[idx] <= pwdata & lpcp_pkg::REG_MASK[idx];
    end
  end

  assign w_raw = regs_r[lpcp_pkg::REG_SIZE][15:0];
  assign h_raw = regs_r[lpcp_pkg::REG_SIZE][31:16];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cfg.rot[k][0] = regs_r[k][15:0];
      cfg.rot[k][1] = regs_r[k][31:16];
      cfg.rot[k][2] = regs_r[k][47:32];
    end
    cfg.trans[0] = regs_r[lpcp_pkg::REG_TRANS][19:0];
    cfg.trans[1] = regs_r[lpcp_pkg::REG_TRANS][39:20];
    cfg.trans[2] = regs_r[lpcp_pkg::REG_TRANS][59:40];
    cfg.fx       = regs_r[lpcp_pkg::REG_FOCAL][23:0];
    cfg.fy       = regs_r[lpcp_pkg::REG_FOCAL][47:24];
    cfg.cx       = regs_r[lpcp_pkg::REG_PRINC][23:0];
    cfg.cy       = regs_r[lpcp_pkg::REG_PRINC][47:24];
    // clamp oversized image dimensions
    cfg.width    = (w_raw > 16'(lpcp_pkg::MAX_IMAGE_DIM)) ?
                   lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM) : w_raw[lpcp_pkg::DIM_W-1:0];
    cfg.height   = (h_raw > 16'(lpcp_pkg::MAX_IMAGE_DIM)) ?
                   lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM) : h_raw[lpcp_pkg::DIM_W-1:0];
    cfg.gain     = regs_r[lpcp_pkg::REG_GAIN][31:0];
  end
endmodule
`default_nettype wire

[src/lpcp_xform.sv]
// Rigid transform into the camera frame: multiply stage, then round, offset, saturate.
// Depends on lpcp_pkg (cfg_t, xf_t).
`default_nettype none
module lpcp_xform (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire lpcp_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  input  wire logic signed [lpcp_pkg::COORD_W-1:0] in_x,
  input  wire logic signed [lpcp_pkg::COORD_W-1:0] in_y,
  input  wire logic signed [lpcp_pkg::COORD_W-1:0] in_z,
  input  wire logic        [lpcp_pkg::INT_W-1:0]   in_intensity,
  output logic                                     out_valid,
  output lpcp_pkg::xf_t                            out_data
);
  logic signed [lpcp_pkg::COORD_W-1:0] pt [3];
  logic signed [39:0]                  prod_r [3][3];
  logic [lpcp_pkg::INT_W-1:0]          a_int_r;
  logic                                a_valid_r;
  logic signed [41:0]                  sum_s [3];
  logic signed [27:0]                  shr_s [3];
  logic signed [28:0]                  off_s [3];
  logic signed [lpcp_pkg::COORD_W-1:0] sat_s [3];
  lpcp_pkg::xf_t                       b_nxt;
  lpcp_pkg::xf_t                       b_r;
  logic                                b_valid_r;

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[k][j] <= $signed(cfg.rot[k][j]) * pt[j];
        end
      end
      a_int_r <= in_intensity;
    end
  end

  // round half up: floor((s + 2^13) / 2^14), then offset and clamp to 24 bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_s[k] = 42'(prod_r[k][0]) + 42'(prod_r[k][1]) + 42'(prod_r[k][2]) + 42'sd8192;
      shr_s[k] = 28'(sum_s[k] >>> 14);
      off_s[k] = 29'(shr_s[k]) + 29'($signed(cfg.trans[k]));
      if (off_s[k] > 29'sd8388607) begin
        sat_s[k] = 24'sh7FFFFF;
      end else if (off_s[k] < -29'sd8388608) begin
        sat_s[k] = -24'sd8388608;
      end else begin
        sat_s[k] = off_s[k][23:0];
      end
    end
    b_nxt.cam.x     = sat_s[0];
    b_nxt.cam.y     = sat_s[1];
    b_nxt.cam.z     = sat_s[2];
    b_nxt.intensity = a_int_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_r;
endmodule
`default_nettype wire

[src/lpcp_proj.sv]
// Pinhole projection front end: products, sums, visibility test and code scaling.
// Hands numerators and shifted divisor to the divider chain. Depends on lpcp_pkg.
`default_nettype none
module lpcp_proj (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire lpcp_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  input  wire lpcp_pkg::xf_t  in_data,
  output logic                out_valid,
  output lpcp_pkg::div_t      out_data
);
  // stage C: products
  logic                 zpos;
  logic [13:0]          dz;
  logic signed [48:0]   c_fxx_r, c_cxz_r, c_fyy_r, c_cyz_r;
  logic [35:0]          c_wz_r, c_hz_r;
  logic [47:0]          c_gain_r;
  logic [21:0]          c_dz_r;
  logic                 c_zpos_r;
  lpcp_pkg::cam_t       c_cam_r;
  logic                 c_valid_r;
  // stage D: sums and scaled codes
  logic signed [49:0]   d_nu_r, d_nv_r;
  logic [43:0]          d_wd_r, d_hd_r;
  logic [30:0]          d_d_r;
  logic [31:0]          lv;
  logic [7:0]           d_label_r;
  logic [26:0]          d_dm_r;
  logic                 d_zpos_r;
  lpcp_pkg::cam_t       d_cam_r;
  logic                 d_valid_r;
  // stage E: visibility and divider setup
  logic                 vis;
  lpcp_pkg::div_t       e_nxt;
  lpcp_pkg::div_t       e_r;
  logic                 e_valid_r;

  assign zpos = !in_data.cam.z[lpcp_pkg::COORD_W-1] && (in_data.cam.z != '0);

  always_comb begin
    if (!zpos) begin
      dz = '0;
    end else if (in_data.cam.z > 24'sd10240) begin
      dz = 14'(lpcp_pkg::DEPTH_LIMIT);
    end else begin
      dz = in_data.cam.z[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_fxx_r  <= $signed({1'b0, cfg.fx}) * in_data.cam.x;
      c_cxz_r  <= $signed({1'b0, cfg.cx}) * in_data.cam.z;
      c_fyy_r  <= $signed({1'b0, cfg.fy}) * in_data.cam.y;
      c_cyz_r  <= $signed({1'b0, cfg.cy}) * in_data.cam.z;
      c_wz_r   <= cfg.width * in_data.cam.z[22:0];
      c_hz_r   <= cfg.height * in_data.cam.z[22:0];
      c_gain_r <= in_data.intensity * cfg.gain;
      c_dz_r   <= dz * 8'(lpcp_pkg::CODE_SCALE);
      c_zpos_r <= zpos;
      c_cam_r  <= in_data.cam;
    end
  end

  assign lv = c_gain_r[47:16];

  always_ff @(posedge clk) begin
    if (en) begin
      d_nu_r    <= 50'(c_fxx_r) + 50'(c_cxz_r);
      d_nv_r    <= 50'(c_fyy_r) + 50'(c_cyz_r);
      d_wd_r    <= {c_wz_r, 8'b0};
      d_hd_r    <= {c_hz_r, 8'b0};
      d_d_r     <= {c_cam_r.z[22:0], 8'b0};
      d_label_r <= (lv > 32'(lpcp_pkg::CODE_SCALE)) ? 8'(lpcp_pkg::CODE_SCALE + 1) :
                   lv[7:0] + 8'd1;
      // divide by 1024 with the shift, by 10 with the reciprocal 52429 / 2^19
      d_dm_r    <= 27'(c_dz_r[21:10] * 16'd52429);
      d_zpos_r  <= c_zpos_r;
      d_cam_r   <= c_cam_r;
    end
  end

  always_comb begin
    vis = d_zpos_r && !d_nu_r[49] && !d_nv_r[49] &&
          (d_nu_r[48:0] < {5'b0, d_wd_r}) && (d_nv_r[48:0] < {5'b0, d_hd_r});
    e_nxt.cam   = d_cam_r;
    e_nxt.vis   = vis;
    e_nxt.label = vis ? d_label_r : '0;
    e_nxt.dcode = vis ? d_dm_r[26:19] + 8'd1 : '0;
    e_nxt.q_u   = '0;
    e_nxt.q_v   = '0;
    if (vis) begin
      e_nxt.rem_u  = {d_nu_r[lpcp_pkg::NUM_W-2:0], 1'b0} + lpcp_pkg::NUM_W'(d_d_r);
      e_nxt.rem_v  = {d_nv_r[lpcp_pkg::NUM_W-2:0], 1'b0} + lpcp_pkg::NUM_W'(d_d_r);
      e_nxt.den_sh = lpcp_pkg::NUM_W'({d_d_r, 1'b0, {(lpcp_pkg::DIM_W-1){1'b0}}});
    end else begin
      // zero numerator against an all-ones divisor keeps the quotient at zero
      e_nxt.rem_u  = '0;
      e_nxt.rem_v  = '0;
      e_nxt.den_sh = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= in_valid;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  assign out_valid = e_valid_r;
  assign out_data  = e_r;
endmodule
`default_nettype wire

[src/lpcp_div_step.sv]
// One restoring-division stage: one quotient bit for column and row per register.
// Depends on lpcp_pkg (div_t).
`default_nettype none
module lpcp_div_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire lpcp_pkg::div_t in_data,
  output logic                out_valid,
  output lpcp_pkg::div_t      out_data
);
  logic           ge_u;
  logic           ge_v;
  lpcp_pkg::div_t step_nxt;
  lpcp_pkg::div_t step_r;
  logic           valid_r;

  always_comb begin
    ge_u            = in_data.rem_u >= in_data.den_sh;
    ge_v            = in_data.rem_v >= in_data.den_sh;
    step_nxt        = in_data;
    step_nxt.rem_u  = ge_u ? in_data.rem_u - in_data.den_sh : in_data.rem_u;
    step_nxt.rem_v  = ge_v ? in_data.rem_v - in_data.den_sh : in_data.rem_v;
    step_nxt.q_u    = {in_data.q_u[lpcp_pkg::DIM_W-2:0], ge_u};
    step_nxt.q_v    = {in_data.q_v[lpcp_pkg::DIM_W-2:0], ge_v};
    step_nxt.den_sh = in_data.den_sh >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = step_r;
endmodule
`default_nettype wire

[src/lidar_point_camera_projection.sv]
// Top level of the lidar point camera projection: config regs, transform, projection,
// divider chain and output skid. Depends on lpcp_pkg, lpcp_if and the lpcp_* modules.
//
//  channel   | direction | handshake       | carries
//  in_pt     | in        | valid/ready     | point_x, point_y, point_z, point_intensity
//  out_pt    | out       | valid/ready     | cam_x/y/z, visible, pixel_col/row, codes
//  psel...   | in        | APB, pready = 1 | 64-bit registers at byte address 8*index
//
// One item per cycle while the skid register is empty; stages: two transform stages, three
// projection stages, one stage per quotient bit of the 13-bit pixel divider, output reg.
// rst_n is synchronous and clears all valid bits; registers reload their reset values.
// A stalled output fills the skid register, which then freezes the whole pipeline.
`default_nettype none
`include "lidar_point_camera_projection_defines.svh"
module lidar_point_camera_projection (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lpcp_in_if.sink                          in_pt,
  lpcp_out_if.source                       out_pt,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lpcp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpcp_pkg::DATA_W-1:0] pwdata,
  output logic      [lpcp_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  localparam int DIV_STEPS = lpcp_pkg::DIM_W;

  lpcp_pkg::cfg_t cfg;
  logic           en;
  logic           xf_valid;
  lpcp_pkg::xf_t  xf_data;
  logic           div_valid [DIV_STEPS+1];
  lpcp_pkg::div_t div_data  [DIV_STEPS+1];
  logic           push;
  lpcp_pkg::div_t out_r;
  logic           out_valid_r;
  lpcp_pkg::div_t skid_r;
  logic           skid_valid_r;

  assign en          = !skid_valid_r;
  assign in_pt.ready = en;

  lpcp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpcp_xform u_xform (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (in_pt.valid),
    .in_x         (in_pt.point_x),
    .in_y         (in_pt.point_y),
    .in_z         (in_pt.point_z),
    .in_intensity (in_pt.point_intensity),
    .out_valid    (xf_valid),
    .out_data     (xf_data)
  );

  lpcp_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (xf_valid),
    .in_data   (xf_data),
    .out_valid (div_valid[0]),
    .out_data  (div_data[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    lpcp_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_valid[i]),
      .in_data   (div_data[i]),
      .out_valid (div_valid[i+1]),
      .out_data  (div_data[i+1])
    );
  end

  // the last divider stage hands over its item whenever the pipeline advances
  assign push = en && div_valid[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_pt.ready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pt.ready) begin
      out_r <= skid_valid_r ? skid_r : div_data[DIV_STEPS];
    end else if (push) begin
      skid_r <= div_data[DIV_STEPS];
    end
  end

  assign out_pt.valid         = out_valid_r;
  assign out_pt.cam_x         = out_r.cam.x;
  assign out_pt.cam_y         = out_r.cam.y;
  assign out_pt.cam_z         = out_r.cam.z;
  assign out_pt.visible       = out_r.vis;
  assign out_pt.pixel_col     = out_r.q_u;
  assign out_pt.pixel_row     = out_r.q_v;
  assign out_pt.label_code    = out_r.label;
  assign out_pt.distance_code = out_r.dcode;

  `LPCP_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r)
  `LPCP_ASSERT(a_hidden_codes, (out_valid_r && !out_r.vis) |-> ({out_r.label, out_r.dcode} == '0))
  `LPCP_ASSERT(a_hidden_pixel, (out_valid_r && !out_r.vis) |-> ({out_r.q_u, out_r.q_v} == '0))
  `LPCP_ASSERT(a_visible_codes, (out_valid_r && out_r.vis) |-> (out_r.label != '0 && out_r.dcode != '0))
  `LPCP_ASSERT_NEXT(a_skid_drains, (skid_valid_r && out_pt.ready), !skid_valid_r)
endmodule
`default_nettype wire

[tb/sv/lpcp_projection_checker.sv]
// Checker for the lidar point camera projection: mirrors the register writes seen on the
// APB port, predicts each projected point and compares it with the result channel.
// Depends on lpcp_pkg and the stream interfaces in lpcp_if.
`default_nettype none
module lpcp_projection_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lpcp_in_if                               in_mon,
  lpcp_out_if                              out_mon,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic                        pready,
  input  wire logic [lpcp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpcp_pkg::DATA_W-1:0] pwdata,
  output int                               fail_count,
  output int                               pending
);
  import lpcp_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      vis;
    logic [DIM_W-1:0]          col;
    logic [DIM_W-1:0]          row;
    logic [CODE_W-1:0]         label;
    logic [CODE_W-1:0]         dcode;
  } pixel_t;

  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  pixel_t            projected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint field_u(logic [DATA_W-1:0] r, int lo, int w);
    logic [DATA_W-1:0] m;
    m = (64'd1 << w) - 64'd1;
    return longint'((r >> lo) & m);
  endfunction

  function automatic pixel_t project_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                           logic [COORD_W-1:0] pz, logic [INT_W-1:0] pint);
    pixel_t res;
    longint p [3];
    longint c [3];
    longint s, z, fx, fy, cxp, cyp, w, h, d, nu, nv, lv, dz;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    for (int k = 0; k < 3; k++) begin
      s = 0;
      for (int j = 0; j < 3; j++) begin
        s += longint'($signed(shadow_regs[k][16*j +: 16])) * p[j];
      end
      // round half up, then offset and saturate
      s = (s + 8192) >>> 14;
      s += longint'($signed(shadow_regs[REG_TRANS][20*k +: 20]));
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      c[k] = s;
    end
    res.cx    = c[0][COORD_W-1:0];
    res.cy    = c[1][COORD_W-1:0];
    res.cz    = c[2][COORD_W-1:0];
    res.vis   = 1'b0;
    res.col   = '0;
    res.row   = '0;
    res.label = '0;
    res.dcode = '0;
    if (c[2] > 0) begin
      z   = c[2];
      fx  = field_u(shadow_regs[REG_FOCAL], 0, 24);
      fy  = field_u(shadow_regs[REG_FOCAL], 24, 24);
      cxp = field_u(shadow_regs[REG_PRINC], 0, 24);
      cyp = field_u(shadow_regs[REG_PRINC], 24, 24);
      w   = field_u(shadow_regs[REG_SIZE], 0, 16);
      h   = field_u(shadow_regs[REG_SIZE], 16, 16);
      if (w > MAX_IMAGE_DIM) w = MAX_IMAGE_DIM;
      if (h > MAX_IMAGE_DIM) h = MAX_IMAGE_DIM;
      d  = z * 256;
      nu = fx * c[0] + cxp * z;
      nv = fy * c[1] + cyp * z;
      if (nu >= 0 && nu < w * d && nv >= 0 && nv < h * d) begin
        res.vis = 1'b1;
        res.col = DIM_W'((2 * nu + d) / (2 * d));
        res.row = DIM_W'((2 * nv + d) / (2 * d));
        lv = (field_u({48'd0, pint}, 0, 16) * field_u(shadow_regs[REG_GAIN], 0, 32)) >>> 16;
        if (lv > CODE_SCALE) lv = CODE_SCALE;
        res.label = CODE_W'(lv + 1);
        dz = (z > DEPTH_LIMIT) ? DEPTH_LIMIT : z;
        res.dcode = CODE_W'(dz * CODE_SCALE / DEPTH_LIMIT + 1);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = REG_RESET[i] & REG_MASK[i];
      projected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (projected_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = projected_q.pop_front();
          if (out_mon.cam_x !== want.cx) report_mismatch("cam_x", out_mon.cam_x, want.cx);
          if (out_mon.cam_y !== want.cy) report_mismatch("cam_y", out_mon.cam_y, want.cy);
          if (out_mon.cam_z !== want.cz) report_mismatch("cam_z", out_mon.cam_z, want.cz);
          if (out_mon.visible !== want.vis)
            report_mismatch("visible", out_mon.visible, want.vis);
          if (out_mon.pixel_col !== want.col)
            report_mismatch("pixel_col", out_mon.pixel_col, want.col);
          if (out_mon.pixel_row !== want.row)
            report_mismatch("pixel_row", out_mon.pixel_row, want.row);
          if (out_mon.label_code !== want.label)
            report_mismatch("label_code", out_mon.label_code, want.label);
          if (out_mon.distance_code !== want.dcode)
            report_mismatch("distance_code", out_mon.distance_code, want.dcode);
        end
      end
      if (in_mon.valid && in_mon.ready)
        projected_q.insert(projected_q.size(),
                           project_point(in_mon.point_x, in_mon.point_y, in_mon.point_z,
                                         in_mon.point_intensity));
      if (psel && penable && pwrite && pready)
        shadow_regs[paddr[ADDR_W-1:3]] = pwdata & REG_MASK[paddr[ADDR_W-1:3]];
    end
    pending = projected_q.size();
  end
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Top of the projection testbench: clock, reset, register setup, point stimulus and verdict.
// Depends on lpcp_pkg, lpcp_if, the block itself and lpcp_projection_checker.
`default_nettype none
module testbench;
  import lpcp_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 178;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int                fail_count, pending, idle_cycles;
  bit                steady_in, steady_out;
  logic [DATA_W-1:0] reg_set [NUM_REGS];

  lpcp_in_if  in_pt ();
  lpcp_out_if out_pt ();

  lidar_point_camera_projection uut (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_pt(out_pt.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  lpcp_projection_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_pt), .out_mon(out_pt), .psel(psel),
    .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_pt.valid            = 1'b0;
    in_pt.point_x          = '0;
    in_pt.point_y          = '0;
    in_pt.point_z          = '0;
    in_pt.point_intensity  = '0;
    out_pt.ready           = 1'b0;
    steady_in              = 1'b0;
    steady_out             = 1'b0;
  end

  // result side: random stalls, none while steady_out is set
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_pt.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pt.ready <= 1'b1;
      do @(posedge clk); while (!out_pt.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_pt.valid && in_pt.ready) || (out_pt.valid && out_pt.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[2:0], reg_set[i]);
  endtask

  // hold until every projected item is back, then let the pipeline empty
  task automatic drain();
    in_pt.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic [15:0] it);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pt.valid           <= 1'b1;
    in_pt.point_x         <= x;
    in_pt.point_y         <= y;
    in_pt.point_z         <= z;
    in_pt.point_intensity <= it;
    do @(posedge clk); while (!in_pt.ready);
  endtask

  function automatic logic [47:0] near_identity_row(int k);
    logic [47:0] r;
    int          v;
    for (int j = 0; j < 3; j++) begin
      v = (j == k ? 16384 : 0) + $urandom_range(0, 3000) - 1500;
      r[16*j +: 16] = v[15:0];
    end
    return r;
  endfunction

  task automatic pick_regs();
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < NUM_REGS; i++) reg_set[i] = {$urandom(), $urandom()};
    end else begin
      for (int k = 0; k < 3; k++) reg_set[k] = {16'd0, near_identity_row(k)};
      reg_set[REG_TRANS] = {4'd0, 8'd0, 12'($urandom_range(0, 4095)),
                            8'd0, 12'($urandom_range(0, 4095)),
                            8'd0, 12'($urandom_range(0, 4095))};
      reg_set[REG_FOCAL] = {16'd0, 24'($urandom_range(25600, 512000)),
                            24'($urandom_range(25600, 512000))};
      reg_set[REG_PRINC] = {16'd0, 24'($urandom_range(0, 256000)),
                            24'($urandom_range(0, 256000))};
      reg_set[REG_SIZE]  = {32'd0, 16'($urandom_range(0, 5000)),
                            16'($urandom_range(0, 5000))};
      reg_set[REG_GAIN]  = {32'd0, $urandom()};
    end
  endtask

  task automatic send_random_point();
    int          mode, zz, xx, yy;
    logic [15:0] it;
    mode = $urandom_range(0, 9);
    it   = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom());
    if (mode < 6) begin
      // point in front of the camera, with x and y within plus or minus its depth
      zz = $urandom_range(1, 40000);
      xx = $urandom_range(0, 2 * zz) - zz;
      yy = $urandom_range(0, 2 * zz) - zz;
      send_point(xx[23:0], yy[23:0], zz[23:0], it);
    end else if (mode < 8) begin
      xx = $urandom_range(0, 200) - 100;
      yy = $urandom_range(0, 200) - 100;
      zz = $urandom_range(0, 200) - 100;
      send_point(xx[23:0], yy[23:0], zz[23:0], it);
    end else begin
      send_point(24'($urandom()), 24'($urandom()), 24'($urandom()), it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: identity, fx = fy = 500, 640x480
    send_point(24'd0, 24'd0, 24'd1024, 16'd0);
    send_point(24'd1024, -24'sd512, 24'd2048, 16'd300);
    send_point(24'd0, 24'd0, 24'd0, 16'd65535);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000, 16'h0000);
    drain();

    // unit focal length, no principal offset: pixel equals x/z
    reg_set[REG_ROT_X] = 64'd16384;
    reg_set[REG_ROT_Y] = 64'd16384 << 16;
    reg_set[REG_ROT_Z] = 64'd16384 << 32;
    reg_set[REG_TRANS] = '0;
    reg_set[REG_FOCAL] = {16'd0, 24'd256, 24'd256};
    reg_set[REG_PRINC] = '0;
    reg_set[REG_SIZE]  = {32'd0, 16'd480, 16'd640};
    reg_set[REG_GAIN]  = 64'd65536;
    load_regs();
    send_point(24'd1279, 24'd0, 24'd2, 16'd65535);   // rounds up to the width
    send_point(24'd1280, 24'd0, 24'd2, 16'd100);     // just outside
    send_point(24'd0, 24'd959, 24'd2, 16'd1);        // rounds up to the height
    send_point(-24'sd1, 24'd0, 24'd2, 16'd1);        // left of the image
    send_point(24'd0, 24'd0, -24'sd5, 16'd1);        // behind the camera
    send_point(24'd0, 24'd0, 24'd5120, 16'd254);     // half the depth limit
    send_point(24'd0, 24'd0, 24'd20480, 16'd255);    // beyond the depth limit
    send_point(24'd0, 24'd0, 24'd10240, 16'd10);
    drain();

    // rounding halves, saturation, extreme focal and an empty image
    reg_set[REG_ROT_X] = 64'd8192;
    reg_set[REG_ROT_Y] = 64'h8000_8000_8000;
    reg_set[REG_ROT_Z] = 64'h7FFF_7FFF_7FFF;
    reg_set[REG_TRANS] = {4'd0, 20'd0, 20'h80000, 20'h7FFFF};
    reg_set[REG_FOCAL] = 64'hFFFF_FFFF_FFFF;
    reg_set[REG_PRINC] = 64'hFFFF_FFFF_FFFF;
    reg_set[REG_SIZE]  = 64'd0;
    reg_set[REG_GAIN]  = 64'hFFFF_FFFF;
    load_regs();
    send_point(24'd1, 24'd1, 24'd1, 16'hFFFF);
    send_point(-24'sd1, -24'sd1, 24'd1, 16'hFFFF);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000, 16'hFFFF);
    drain();

    // oversized image clamps, all-ones translation, maximum gain
    reg_set[REG_ROT_X] = 64'd16384;
    reg_set[REG_ROT_Y] = 64'd16384 << 16;
    reg_set[REG_ROT_Z] = 64'd16384 << 32;
    reg_set[REG_TRANS] = 64'h0FFF_FFFF_FFFF_FFFF;
    reg_set[REG_FOCAL] = {16'd0, 24'd256, 24'd256};
    reg_set[REG_PRINC] = '0;
    reg_set[REG_SIZE]  = 64'hFFFF_FFFF;
    load_regs();
    send_point(24'd8191, 24'd8191, 24'd3, 16'hFFFF);
    send_point(24'd4000, 24'd100, 24'd1, 16'd1);
    send_point(24'd12000, 24'd12000, 24'd3, 16'd7);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      pick_regs();
      load_regs();
      steady_in  = (ph == 3);
      steady_out = (ph == 3) || (ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 80) begin
          // hold the sender until the pipeline is empty
          in_pt.valid <= 1'b0;
          repeat (2) @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random_point();
      end
      drain();
    end

    steady_out = 1'b0;
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
